// ----- rtl/core/glyph_row_pixel_expander_core_defines.svh -----
// assertion helpers shared by the expander modules
`ifndef GLYPH_ROW_PIXEL_EXPANDER_CORE_DEFINES_SVH
`define GLYPH_ROW_PIXEL_EXPANDER_CORE_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define GRPE_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define GRPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/grpe_pkg.sv -----
package grpe_pkg;

  localparam int unsigned GlyphWidth = 16;
  localparam int unsigned OffW       = $clog2(GlyphWidth);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  // operation codes
  localparam logic [1:0] OpPlot    = 2'd0;
  localparam logic [1:0] OpMasked  = 2'd1;
  localparam logic [1:0] OpOverlay = 2'd2;
  localparam logic [1:0] OpUnused  = 2'd3;

  // pixel formats
  localparam logic [1:0] FmtRgb1555 = 2'd0;
  localparam logic [1:0] FmtRgb565  = 2'd1;
  localparam logic [1:0] FmtRgb24   = 2'd2;
  localparam logic [1:0] FmtXrgb32  = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPixelFormat  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgScreenWidth  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgScreenHeight = 2'd2;

  localparam logic [1:0]  FmtReset    = FmtXrgb32;
  localparam logic [15:0] WidthReset  = 16'd640;
  localparam logic [15:0] HeightReset = 16'd480;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] row_y;
    logic [15:0] column_x;
    logic [15:0] glyph_bits;
    logic [15:0] select_mask;
    logic [24:0] fg_first;
    logic [24:0] bg_first;
    logic [24:0] fg_second;
    logic [24:0] bg_second;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_y;
    logic [15:0] pixel_x;
    logic [23:0] pixel_value;
    logic        last;
  } out_item_t;

  // one classified glyph row waiting for the back end
  typedef struct packed {
    logic [1:0]            op;
    logic [15:0]           row_y;
    logic [15:0]           column_x;
    logic [GlyphWidth-1:0] glyph;
    logic [GlyphWidth-1:0] sel;
    logic [GlyphWidth-1:0] emit;   // indexed by column offset
    logic [23:0]           fg0;
    logic [23:0]           bg0;
    logic [23:0]           fg1;
    logic [23:0]           bg1;
  } work_t;

  function automatic logic [23:0] to_pixel(input logic [24:0] c, input logic [1:0] fmt);
    logic       a;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [23:0] v;
    a = c[24];
    r = c[23:16];
    g = c[15:8];
    b = c[7:0];
    unique case (fmt) inside
      FmtRgb1555: v = {8'h00, a, r[7:3], g[7:3], b[7:3]};
      FmtRgb565:  v = {8'h00, r[7:3], g[7:2], b[7:3]};
      FmtRgb24, FmtXrgb32: v = {r, g, b};
      default:    v = {r, g, b};
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/grpe_front.sv -----
module grpe_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  grpe_pkg::in_item_t in_data_i,
  input  logic               full_i,
  output logic               push_o,
  output grpe_pkg::work_t    push_data_o
);
  import grpe_pkg::*;

  logic [1:0]  fmt_q, fmt_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;

  logic                  live;
  logic [GlyphWidth-1:0] glyph_ext;
  logic [GlyphWidth-1:0] sel_ext;
  logic [GlyphWidth-1:0] emit;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    fmt_d    = fmt_q;
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgPixelFormat:  fmt_d    = cfg_data_i[1:0];
        CfgScreenWidth:  width_d  = cfg_data_i;
        CfgScreenHeight: height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FmtReset;
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else begin
      fmt_q    <= fmt_d;
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // glyph bits beyond bit 15 read as zero
  assign glyph_ext = GlyphWidth'({{GlyphWidth{1'b0}}, in_data_i.glyph_bits});
  assign sel_ext   = GlyphWidth'({{GlyphWidth{1'b0}}, in_data_i.select_mask});

  assign live = (in_data_i.operation != OpUnused) && (in_data_i.row_y < height_q);

  always_comb begin
    logic [16:0] col;
    logic        on_screen;
    logic        bit_set;
    emit = '0;
    for (int unsigned off = 0; off < GlyphWidth; off++) begin
      // sum kept one bit wider so it never wraps back on screen
      col       = {1'b0, in_data_i.column_x} + 17'(off);
      on_screen = col < {1'b0, width_q};
      bit_set   = glyph_ext[GlyphWidth-1-off];
      emit[off] = live && on_screen && ((in_data_i.operation != OpOverlay) || bit_set);
    end
  end

  assign in_ready_o = !full_i;
  // rows that draw nothing are taken and dropped here
  assign push_o     = in_valid_i && !full_i && (emit != '0);

  always_comb begin
    push_data_o.op       = in_data_i.operation;
    push_data_o.row_y    = in_data_i.row_y;
    push_data_o.column_x = in_data_i.column_x;
    push_data_o.glyph    = glyph_ext;
    push_data_o.sel      = sel_ext;
    push_data_o.emit     = emit;
    push_data_o.fg0      = to_pixel(in_data_i.fg_first, fmt_q);
    push_data_o.bg0      = to_pixel(in_data_i.bg_first, fmt_q);
    push_data_o.fg1      = to_pixel(in_data_i.fg_second, fmt_q);
    push_data_o.bg1      = to_pixel(in_data_i.bg_second, fmt_q);
  end

endmodule

// ----- rtl/core/grpe_queue.sv -----
`include "glyph_row_pixel_expander_core_defines.svh"

module grpe_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  grpe_pkg::work_t push_data_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            head_valid_o,
  output grpe_pkg::work_t head_o
);
  import grpe_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

  work_t           entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == CntFull);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  `GRPE_ASSERT(a_no_overflow, !push_i || !full_o || pop_i, "push into full queue")
  `GRPE_ASSERT(a_no_underflow, !pop_i || head_valid_o, "pop from empty queue")

endmodule

// ----- rtl/core/grpe_back.sv -----
`include "glyph_row_pixel_expander_core_defines.svh"

module grpe_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  grpe_pkg::work_t     head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output grpe_pkg::out_item_t out_data_o
);
  import grpe_pkg::*;

  localparam logic [OffW-1:0] OffMax = OffW'(GlyphWidth - 1);

  logic [GlyphWidth-1:0] done_q, done_d;
  logic [GlyphWidth-1:0] remaining;
  logic [GlyphWidth-1:0] pick_mask;
  logic [OffW-1:0]       pick_off;
  logic [OffW-1:0]       pos;
  logic                  advance;
  logic                  fire;
  logic                  last;
  logic                  bit_set;
  logic                  pair_sel;
  logic [23:0]           value;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q;

  assign remaining = head_i.emit & ~done_q;

  // highest drawn offset first, which is the rightmost pixel
  always_comb begin
    pick_off = '0;
    for (int unsigned i = 0; i < GlyphWidth; i++) begin
      if (remaining[i]) begin
        pick_off = OffW'(i);
      end
    end
  end

  assign pick_mask = GlyphWidth'(1) << pick_off;
  assign last      = (remaining & ~pick_mask) == '0;
  assign advance   = !out_valid_q || out_ready_i;
  assign fire      = head_valid_i && advance;
  assign pop_o     = fire && last;

  assign pos      = OffMax - pick_off;
  assign bit_set  = head_i.glyph[pos];
  assign pair_sel = head_i.sel[pos];

  always_comb begin
    unique case (head_i.op)
      OpPlot:   value = bit_set ? head_i.fg0 : head_i.bg0;
      OpMasked: begin
        if (bit_set) begin
          value = pair_sel ? head_i.fg1 : head_i.fg0;
        end else begin
          value = pair_sel ? head_i.bg1 : head_i.bg0;
        end
      end
      default:  value = head_i.fg0;
    endcase
  end

  always_comb begin
    done_d = done_q;
    if (fire) begin
      done_d = last ? '0 : (done_q | pick_mask);
    end
    out_valid_d = advance ? fire : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.pixel_y     <= head_i.row_y;
      out_q.pixel_x     <= head_i.column_x + 16'(pick_off);
      out_q.pixel_value <= value;
      out_q.last        <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `GRPE_ASSERT(a_done_in_head, (done_q & ~head_i.emit) == '0, "sent pixel not in head row")
  `GRPE_ASSERT_NEXT(a_pop_marks_last, pop_o, out_valid_q && out_q.last, "pop without last pixel")

endmodule

// ----- rtl/core/glyph_row_pixel_expander_core.sv -----
// channel  direction  handshake              payload
// cfg      in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
// in       in         in_valid_i/in_ready_o   in_data_i (one glyph row)
// out      out        out_valid_o/out_ready_i out_data_o (one pixel write)
//
// one pixel write per cycle unless the output stalls; the back end steps through the drawn
// offsets of the queue head, so a row gives 0 to 16 pixel writes
// an accepted row is written into the row queue, and its first pixel is then registered in
// the output register; rows drawing nothing are dropped
// reset restores format 32-bit, 640 x 480 and empties the two-entry row queue
// a stalled output holds its pixel; the front keeps accepting until the queue is full
module glyph_row_pixel_expander_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  grpe_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output grpe_pkg::out_item_t out_data_o
);
  import grpe_pkg::*;

  logic  push;
  work_t push_data;
  logic  full;
  logic  pop;
  logic  head_valid;
  work_t head;

  grpe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  grpe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  grpe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ----- dv/glyph_row_pixel_expander_core_tb.sv -----
`timescale 1ns / 100ps

module glyph_row_pixel_expander_core_tb;
  import grpe_pkg::*;

  localparam int unsigned SettleCycles   = 40;
  localparam int unsigned WatchdogLimit  = 4000;
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned LongHoldAfter  = 40;
  // index with no register behind it, writes are dropped
  localparam logic [CfgIdxW-1:0] CfgUnmapped = 2'd3;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_data_o;

  // register mirror
  logic [1:0]  fmt_now    = FmtReset;
  logic [15:0] width_now  = WidthReset;
  logic [15:0] height_now = HeightReset;

  in_item_t  pending_rows[$];
  out_item_t pixel_writes_due[$];

  int unsigned rows_taken     = 0;
  int unsigned pixels_checked = 0;
  int unsigned mismatches     = 0;
  int unsigned settings_used  = 0;
  int unsigned idle_cycles    = 0;
  int unsigned send_gap       = 0;
  int unsigned ready_gap      = 0;
  int unsigned hold_left      = 0;
  logic        long_hold_done = 1'b0;
  logic        idle_on        = 1'b1;
  logic        in_fire        = 1'b0;

  glyph_row_pixel_expander_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [23:0] pack_colour(input logic [24:0] c, input logic [1:0] fmt);
    case (fmt)
      FmtRgb1555: return {8'h00, c[24], c[23:19], c[15:11], c[7:3]};
      FmtRgb565:  return {8'h00, c[23:19], c[15:10], c[7:3]};
      default:    return c[23:0];
    endcase
  endfunction

  // expected pixel writes of one glyph row, rightmost column first
  function automatic void expand_row(input in_item_t r);
    logic [23:0] fg [2];
    logic [23:0] bg [2];
    logic [16:0] col;
    logic        bit_set;
    logic        pair;
    int          off;
    out_item_t   px;
    out_item_t   row_px[$];
    fg[0] = pack_colour(r.fg_first, fmt_now);
    bg[0] = pack_colour(r.bg_first, fmt_now);
    fg[1] = pack_colour(r.fg_second, fmt_now);
    bg[1] = pack_colour(r.bg_second, fmt_now);
    if (r.operation == OpUnused || r.row_y >= height_now) return;
    for (off = GlyphWidth - 1; off >= 0; off--) begin
      // sum kept one bit wider so it never wraps back on screen
      col     = {1'b0, r.column_x} + 17'(off);
      bit_set = r.glyph_bits[GlyphWidth - 1 - off];
      pair    = r.select_mask[GlyphWidth - 1 - off];
      if (col >= {1'b0, width_now}) continue;
      if (r.operation == OpOverlay && !bit_set) continue;
      px.pixel_y = r.row_y;
      px.pixel_x = col[15:0];
      case (r.operation)
        OpPlot:   px.pixel_value = bit_set ? fg[0] : bg[0];
        OpMasked: px.pixel_value = bit_set ? fg[pair] : bg[pair];
        default:  px.pixel_value = fg[0];
      endcase
      px.last = 1'b0;
      row_px.push_back(px);
    end
    if (row_px.size() > 0) begin
      px      = row_px.pop_back();
      px.last = 1'b1;
      row_px.push_back(px);
    end
    foreach (row_px[i]) pixel_writes_due.push_back(row_px[i]);
  endfunction

  function automatic void check_pixel(input out_item_t got);
    out_item_t want;
    if (pixel_writes_due.size() == 0) begin
      $error("pixel write at x %0d y %0d with no request pending", got.pixel_x, got.pixel_y);
      mismatches++;
      return;
    end
    want = pixel_writes_due.pop_front();
    if (got.pixel_y !== want.pixel_y) begin
      $error("pixel_y: expected %0d, actual %0d", want.pixel_y, got.pixel_y);
      mismatches++;
    end
    if (got.pixel_x !== want.pixel_x) begin
      $error("pixel_x: expected %0d, actual %0d", want.pixel_x, got.pixel_x);
      mismatches++;
    end
    if (got.pixel_value !== want.pixel_value) begin
      $error("pixel_value: expected 0x%06h, actual 0x%06h", want.pixel_value, got.pixel_value);
      mismatches++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0b, actual %0b", want.last, got.last);
      mismatches++;
    end
  endfunction

  function automatic in_item_t random_row(input logic [15:0] w, input logic [15:0] h);
    in_item_t r;
    r.operation = ($urandom_range(0, 15) == 0) ? OpUnused : 2'($urandom_range(0, 2));
    r.row_y = (h == 0 || $urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, h - 1));
    case ($urandom_range(0, 3))
      0:       r.column_x = 16'($urandom);
      // straddle the right edge
      1:       r.column_x = 16'($urandom_range(w > 16 ? w - 16 : 0, w));
      default: r.column_x = 16'($urandom_range(0, w > 16 ? w - 16 : 0));
    endcase
    case ($urandom_range(0, 7))
      0:       r.glyph_bits = 16'h0000;
      1:       r.glyph_bits = 16'hFFFF;
      default: r.glyph_bits = 16'($urandom);
    endcase
    r.select_mask = 16'($urandom);
    r.fg_first    = 25'($urandom);
    r.bg_first    = 25'($urandom);
    r.fg_second   = 25'($urandom);
    r.bg_second   = 25'($urandom);
    return r;
  endfunction

  task automatic queue_random(input int n, input logic [15:0] w, input logic [15:0] h);
    repeat (n) pending_rows.push_back(random_row(w, h));
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_screen(input logic [1:0] fmt, input logic [15:0] w, input logic [15:0] h);
    // upper data bits of the format write are don't-care
    write_reg(CfgPixelFormat, {14'($urandom), fmt});
    write_reg(CfgScreenWidth, w);
    write_reg(CfgScreenHeight, h);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // sender holds until every pixel is back and the pipe has gone quiet
  task automatic settle();
    while (pending_rows.size() != 0 || in_valid_i) @(posedge clk_i);
    while (pixel_writes_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    in_fire <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgPixelFormat:  fmt_now = cfg_data_i[1:0];
          CfgScreenWidth:  width_now = cfg_data_i;
          CfgScreenHeight: height_now = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        expand_row(in_data_i);
        rows_taken++;
      end
      if (out_valid_o && out_ready_i) begin
        check_pixel(out_data_o);
        pixels_checked++;
      end
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
          (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!in_valid_i || in_fire) begin
      if (send_gap == 0 && idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 6);
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_rows.size() > 0) begin
        in_data_i  <= pending_rows.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    // one long output hold so the row queue fills and backs up the input
    if (!long_hold_done && rows_taken >= LongHoldAfter) begin
      long_hold_done = 1'b1;
      hold_left      = LongHoldCycles;
    end
    if (ready_gap == 0 && idle_on && $urandom_range(0, 5) == 0) ready_gap = $urandom_range(1, 6);
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    logic [1:0]  fmt;
    logic [15:0] w;
    logic [15:0] h;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: 32-bit, 640 x 480
    pending_rows.push_back(in_item_t'{OpPlot, 16'd0, 16'd0, 16'hFFFF, 16'h0000,
                                      25'h1FFFFFF, 25'h0000000, 25'h0000000, 25'h0000000});
    pending_rows.push_back(in_item_t'{OpPlot, 16'd1, 16'd0, 16'h0000, 16'hFFFF,
                                      25'h0000000, 25'h1FFFFFF, 25'h1FFFFFF, 25'h1FFFFFF});
    pending_rows.push_back(in_item_t'{OpPlot, 16'd479, 16'd624, 16'h8001, 16'h0000,
                                      25'h1123456, 25'h0ABCDEF, 25'h0000000, 25'h0000000});
    // right edge clipping, partly and fully, no wrap past 65535
    pending_rows.push_back(in_item_t'{OpPlot, 16'd2, 16'd630, 16'hA5A5, 16'h0000,
                                      25'h0FF0000, 25'h000FF00, 25'h0000000, 25'h0000000});
    pending_rows.push_back(in_item_t'{OpPlot, 16'd3, 16'hFFFF, 16'hFFFF, 16'h0000,
                                      25'h1FFFFFF, 25'h1FFFFFF, 25'h0000000, 25'h0000000});
    pending_rows.push_back(in_item_t'{OpPlot, 16'd4, 16'hFFF8, 16'hFFFF, 16'hFFFF,
                                      25'h1FFFFFF, 25'h1FFFFFF, 25'h1FFFFFF, 25'h1FFFFFF});
    pending_rows.push_back(in_item_t'{OpMasked, 16'd5, 16'd100, 16'hF0F0, 16'hAAAA,
                                      25'h0111111, 25'h0222222, 25'h1333333, 25'h1444444});
    pending_rows.push_back(in_item_t'{OpMasked, 16'd6, 16'd100, 16'hFFFF, 16'hFFFF,
                                      25'h0111111, 25'h0222222, 25'h1333333, 25'h1444444});
    pending_rows.push_back(in_item_t'{OpMasked, 16'd7, 16'd100, 16'h0000, 16'h0000,
                                      25'h0111111, 25'h0222222, 25'h1333333, 25'h1444444});
    pending_rows.push_back(in_item_t'{OpMasked, 16'd8, 16'd635, 16'h3C3C, 16'h5A5A,
                                      25'h1F0F0F0, 25'h00F0F0F, 25'h1AA55AA, 25'h055AA55});
    // overlay with nothing set draws nothing
    pending_rows.push_back(in_item_t'{OpOverlay, 16'd9, 16'd0, 16'h0000, 16'hFFFF,
                                      25'h1FFFFFF, 25'h1FFFFFF, 25'h1FFFFFF, 25'h1FFFFFF});
    pending_rows.push_back(in_item_t'{OpOverlay, 16'd10, 16'd0, 16'h8000, 16'h0000,
                                      25'h1ABCDEF, 25'h0000000, 25'h0000000, 25'h0000000});
    pending_rows.push_back(in_item_t'{OpOverlay, 16'd11, 16'd0, 16'h0001, 16'h0000,
                                      25'h0FEDCBA, 25'h0000000, 25'h0000000, 25'h0000000});
    pending_rows.push_back(in_item_t'{OpOverlay, 16'd12, 16'd200, 16'h6996, 16'h0F0F,
                                      25'h0808080, 25'h1FFFFFF, 25'h1FFFFFF, 25'h1FFFFFF});
    pending_rows.push_back(in_item_t'{OpUnused, 16'd13, 16'd0, 16'hFFFF, 16'hFFFF,
                                      25'h1FFFFFF, 25'h1FFFFFF, 25'h1FFFFFF, 25'h1FFFFFF});
    // rows at and past the bottom edge
    pending_rows.push_back(in_item_t'{OpPlot, 16'd480, 16'd0, 16'hFFFF, 16'h0000,
                                      25'h1FFFFFF, 25'h0000000, 25'h0000000, 25'h0000000});
    pending_rows.push_back(in_item_t'{OpPlot, 16'hFFFF, 16'd0, 16'hFFFF, 16'h0000,
                                      25'h1FFFFFF, 25'h0000000, 25'h0000000, 25'h0000000});
    pending_rows.push_back(in_item_t'{OpPlot, 16'd20, 16'd0, 16'h1234, 16'h0000,
                                      25'h1000000, 25'h0FFFFFF, 25'h0000000, 25'h0000000});
    pending_rows.push_back(in_item_t'{OpMasked, 16'd21, 16'd0, 16'h5555, 16'h3333,
                                      25'h1C3A5F7, 25'h03C5A7E, 25'h10F1E2D, 25'h0E1D2C3});
    settle();

    set_screen(FmtRgb1555, 16'd640, 16'd480);
    queue_random(70, 16'd640, 16'd480);
    settle();

    write_reg(CfgUnmapped, 16'hFFFF);
    set_screen(FmtRgb565, 16'hFFFF, 16'hFFFF);
    queue_random(70, 16'hFFFF, 16'hFFFF);
    settle();

    set_screen(FmtRgb24, 16'd40, 16'd30);
    queue_random(70, 16'd40, 16'd30);
    settle();

    // empty screen: every row is dropped
    set_screen(FmtXrgb32, 16'd0, 16'd0);
    queue_random(20, 16'd0, 16'd0);
    settle();

    repeat (2) begin
      fmt = 2'($urandom_range(0, 3));
      w   = $urandom_range(0, 1) ? 16'($urandom_range(16, 700)) : 16'($urandom);
      h   = $urandom_range(0, 1) ? 16'($urandom_range(1, 500)) : 16'($urandom);
      set_screen(fmt, w, h);
      queue_random(35, w, h);
      settle();
    end

    // closing stretch at full rate on both sides
    idle_on = 1'b0;
    set_screen(FmtRgb24, 16'd640, 16'd480);
    queue_random(90, 16'd640, 16'd480);
    settle();

    $display("%0d glyph rows driven under %0d screen settings, %0d pixel writes compared",
             rows_taken, settings_used + 1, pixels_checked);
    $display("all four pixel formats, edge clipping, an empty screen and a long output hold");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
